@@ design/vmph_pkg.sv @@
// vmph_pkg: shared constants for the vector magnitude peak hold block.
// No dependencies; used by the top level and its checker.
package vmph_pkg;

  // width of every result field on the output side
  localparam int unsigned FIELD_W = 16;

  // shift register width and its reset value
  localparam int unsigned SHIFT_W = 4;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

endpackage

@@ design/vector_magnitude_peak_hold_top.sv @@
// vector_magnitude_peak_hold_top: 3-axis magnitude with peak hold, bit-serial datapath.
// Depends on vmph_pkg (field widths, shift register reset value).
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one sample: x_raw_i, y_raw_i, z_raw_i,
//   SAMPLE_WIDTH bits each, two's complement. Each component is shifted right
//   arithmetically by the shift register, then squared and summed.
//   Output channel (out_valid_o/out_ready_i) returns, per sample, the floor square root
//   of the sum, the peak magnitude, the shifted components of the peak sample and a
//   new_peak flag. The peak only moves on a strictly larger sum of squares.
//   Config: cfg_wr_en_i writes cfg_wr_data_i to the shift register; write only while idle.
// Timing
//   One sample at a time. After an input transfer the squares are built by a bit-serial
//   shift-add multiplier (one multiplier bit of each axis per cycle), a compare state
//   checks against the peak, and a restoring square root takes two radicand bits per cycle.
// Reset and stalls
//   Reset clears the peak to zero, sets the shift to 4 and empties the output register.
//   The output register holds a result while the receiver stalls; the next sample is
//   still accepted and worked on, and only waits at its last step for the register.
module vector_magnitude_peak_hold_top #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_wr_en_i,
  input  logic [vmph_pkg::SHIFT_W-1:0]    cfg_wr_data_i,
  // sample input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  x_raw_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  y_raw_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  z_raw_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vmph_pkg::FIELD_W-1:0]    magnitude_o,
  output logic [vmph_pkg::FIELD_W-1:0]    peak_magnitude_o,
  output logic signed [vmph_pkg::FIELD_W-1:0] peak_x_o,
  output logic signed [vmph_pkg::FIELD_W-1:0] peak_y_o,
  output logic signed [vmph_pkg::FIELD_W-1:0] peak_z_o,
  output logic                            new_peak_o
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam int unsigned AW = 2 * W + 2;   // product accumulator width
  localparam int unsigned FW = vmph_pkg::FIELD_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // magnitude of the arithmetically shifted component
  function automatic logic [W-1:0] comp_mag(input logic [W-1:0] raw,
                                            input logic [vmph_pkg::SHIFT_W-1:0] s);
    logic [W-1:0] a;
    a = raw[W-1] ? ~raw : raw;
    return (a >> s) + {{(W-1){1'b0}}, raw[W-1]};
  endfunction

  // 16-bit two's complement field of the shifted component
  function automatic logic [FW-1:0] comp_field(input logic [W-1:0] mag, input logic neg);
    logic [W+FW-1:0] e;
    e = {{FW{1'b0}}, mag};
    if (neg) begin
      e = -e;
    end
    return e[FW-1:0];
  endfunction

  logic [2:0]                  state_q, state_d;
  logic [vmph_pkg::SHIFT_W-1:0] shift_q;
  logic [CW-1:0]               cnt_q;
  logic                        last_step;

  // per-sample working registers
  logic [W-1:0]  mx_q, my_q, mz_q;      // multiplicands
  logic [W-1:0]  sx_q, sy_q, sz_q;      // multiplier bits, shifted out lsb first
  logic [FW-1:0] bx_q, by_q, bz_q;      // candidate peak point
  logic [AW-1:0] acc_q, acc_d;
  logic [2*W-1:0] rad_q;                // radicand, consumed msb pair first
  logic [W+1:0]  rem_q, rem_d;
  logic [W-1:0]  root_q, root_d;
  logic          fresh_q;

  // peak state
  logic [2*W-1:0] peak_sum_q;
  logic [FW-1:0]  peak_mag_q;
  logic [FW-1:0]  peak_x_q, peak_y_q, peak_z_q;

  // output register
  logic          out_valid_q;
  logic [FW-1:0] out_mag_q, out_pmag_q, out_px_q, out_py_q, out_pz_q;
  logic          out_new_q;

  logic          in_xfer, out_free;
  logic [W+1:0]  add;
  logic [W+2:0]  hi_sum;
  logic [W+3:0]  rem_sh, trial;
  logic [W+4:0]  diff;
  logic          ge;
  logic [2*W-1:0] sum;
  logic          gt;
  logic [W-1:0]  lx, ly, lz;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_step  = (cnt_q == CW'(W - 1));

  assign lx = comp_mag(x_raw_i, shift_q);
  assign ly = comp_mag(y_raw_i, shift_q);
  assign lz = comp_mag(z_raw_i, shift_q);

  // shift-add step: one multiplier bit of every axis, then shift right
  always_comb begin
    add = {2'b00, mx_q & {W{sx_q[0]}}} + {2'b00, my_q & {W{sy_q[0]}}}
        + {2'b00, mz_q & {W{sz_q[0]}}};
    hi_sum = {1'b0, acc_q[AW-1:W]} + {1'b0, add};
    acc_d  = {hi_sum, acc_q[W-1:1]};
  end

  // restoring square root step: two radicand bits in, one root bit out
  always_comb begin
    rem_sh = {rem_q, rad_q[2*W-1:2*W-2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    ge     = !diff[W+4];
    rem_d  = ge ? diff[W+1:0] : rem_sh[W+1:0];
    root_d = {root_q[W-2:0], ge};
  end

  assign sum = acc_q[2*W-1:0];
  assign gt  = sum > peak_sum_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer)   state_d = ST_MUL;
      ST_MUL:  if (last_step) state_d = ST_CMP;
      ST_CMP:                 state_d = ST_SQRT;
      ST_SQRT: if (last_step) state_d = ST_OUT;
      ST_OUT:  if (out_free)  state_d = ST_IDLE;
      default:                state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= vmph_pkg::SHIFT_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      peak_sum_q  <= '0;
      peak_mag_q  <= '0;
      peak_x_q    <= '0;
      peak_y_q    <= '0;
      peak_z_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        shift_q <= cfg_wr_data_i;
      end
      if ((state_q == ST_MUL || state_q == ST_SQRT) && !last_step) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == ST_CMP && gt) begin
        peak_sum_q <= sum;
        peak_x_q   <= bx_q;
        peak_y_q   <= by_q;
        peak_z_q   <= bz_q;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        if (fresh_q) begin
          peak_mag_q <= FW'(root_q);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          mx_q  <= lx;
          my_q  <= ly;
          mz_q  <= lz;
          sx_q  <= lx;
          sy_q  <= ly;
          sz_q  <= lz;
          bx_q  <= comp_field(lx, x_raw_i[W-1]);
          by_q  <= comp_field(ly, y_raw_i[W-1]);
          bz_q  <= comp_field(lz, z_raw_i[W-1]);
          acc_q <= '0;
        end
      end
      ST_MUL: begin
        acc_q <= acc_d;
        sx_q  <= sx_q >> 1;
        sy_q  <= sy_q >> 1;
        sz_q  <= sz_q >> 1;
      end
      ST_CMP: begin
        fresh_q <= gt;
        rad_q   <= sum;
        rem_q   <= '0;
        root_q  <= '0;
      end
      ST_SQRT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= rem_d;
        root_q <= root_d;
      end
      ST_OUT: begin
        if (out_free) begin
          out_mag_q  <= FW'(root_q);
          out_pmag_q <= fresh_q ? FW'(root_q) : peak_mag_q;
          out_px_q   <= peak_x_q;
          out_py_q   <= peak_y_q;
          out_pz_q   <= peak_z_q;
          out_new_q  <= fresh_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign magnitude_o      = out_mag_q;
  assign peak_magnitude_o = out_pmag_q;
  assign peak_x_o         = out_px_q;
  assign peak_y_o         = out_py_q;
  assign peak_z_o         = out_pz_q;
  assign new_peak_o       = out_new_q;

endmodule

@@ design/vmph_checker.sv @@
// vmph_checker: port-level assertions for vector_magnitude_peak_hold_top.
// Depends on vmph_pkg; bound to the top level at the end of this file.
module vmph_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [vmph_pkg::FIELD_W-1:0] magnitude_o,
  input logic [vmph_pkg::FIELD_W-1:0] peak_magnitude_o,
  input logic                         new_peak_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(magnitude_o)
      && $stable(peak_magnitude_o) && $stable(new_peak_o))
    else $error("stalled result changed");

  // one sample in flight: input closes right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a sample is in progress");

  // no result appears in the cycle after a transfer in while none was showing
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // a fresh peak reports its own magnitude
  a_new_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_peak_o |-> peak_magnitude_o == magnitude_o)
    else $error("new peak magnitude mismatch");

endmodule

bind vector_magnitude_peak_hold_top vmph_checker u_vmph_checker (.*);
